FILE: src/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
package bsc_pkg;

  localparam int unsigned CoeffW  = 16;
  localparam int unsigned RawW    = 24;
  localparam int unsigned TempW   = 19;
  localparam int unsigned PresW   = 23;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_C1 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_C2 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_C3 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_C4 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_C5 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_C6 = 3'd5;

  // Calibration words as seen by the datapath
  typedef struct packed {
    logic [CoeffW-1:0] c1;
    logic [CoeffW-1:0] c2;
    logic [CoeffW-1:0] c3;
    logic [CoeffW-1:0] c4;
    logic [CoeffW-1:0] c5;
    logic [CoeffW-1:0] c6;
  } coeff_t;

  // Intermediate results handed from the correction stages to the pressure stages
  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [TempW-1:0] temp;
    logic signed [35:0]      off;
    logic signed [34:0]      sens;
  } corr_t;

endpackage

FILE: src/bsc_cfg_regs.sv
// Calibration word registers written through the configuration port.
module bsc_cfg_regs import bsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoeffW-1:0]  cfg_wdata_i,
  output coeff_t             coeff_o
);

  coeff_t coeff_q, coeff_d;

  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_C1:  coeff_d.c1 = cfg_wdata_i;
        REG_C2:  coeff_d.c2 = cfg_wdata_i;
        REG_C3:  coeff_d.c3 = cfg_wdata_i;
        REG_C4:  coeff_d.c4 = cfg_wdata_i;
        REG_C5:  coeff_d.c5 = cfg_wdata_i;
        REG_C6:  coeff_d.c6 = cfg_wdata_i;
        default: coeff_d = coeff_q; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  assign coeff_o = coeff_q;

endmodule

FILE: src/bsc_corr.sv
// Stages 1-3: dT, the three dT products, and TEMP / OFF / SENS.
module bsc_corr import bsc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  coeff_t          coeff_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [RawW-1:0] d1_i,
  input  logic [RawW-1:0] d2_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output corr_t           out_o
);

  logic v0_q, v1_q, v2_q;
  logic rdy0, rdy1, rdy2;

  // stage 1
  logic [RawW-1:0]    d1_0_q;
  logic signed [24:0] dt_0_q, dt_0_d;
  // stage 2
  logic [RawW-1:0]    d1_1_q;
  logic signed [41:0] pt_1_q, po_1_q, ps_1_q;
  // stage 3
  corr_t              res_2_q, res_2_d;

  logic signed [41:0] tb, tq, ob, oq, sb, sq;
  logic signed [19:0] tsum;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  assign dt_0_d = $signed({1'b0, d2_i}) - $signed({1'b0, coeff_i.c5, 8'h00});

  always_comb begin
    // truncating divides: bias negative values before the arithmetic shift
    tb   = pt_1_q + (pt_1_q[41] ? 42'sd8388607 : 42'sd0);
    tq   = tb >>> 23;
    tsum = tq[19:0] + 20'sd2000;
    if (tsum > 20'sd262143) begin
      res_2_d.temp = 19'sd262143;
    end else if (tsum < -20'sd262144) begin
      res_2_d.temp = -19'sd262144;
    end else begin
      res_2_d.temp = tsum[18:0];
    end

    ob = po_1_q + (po_1_q[41] ? 42'sd127 : 42'sd0);
    oq = ob >>> 7;
    res_2_d.off = $signed({4'b0, coeff_i.c2, 16'h0000}) + oq[35:0];

    sb = ps_1_q + (ps_1_q[41] ? 42'sd255 : 42'sd0);
    sq = sb >>> 8;
    res_2_d.sens = $signed({4'b0, coeff_i.c1, 15'h0000}) + sq[34:0];

    res_2_d.d1 = d1_1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      d1_0_q <= d1_i;
      dt_0_q <= dt_0_d;
    end
    if (rdy1) begin
      d1_1_q <= d1_0_q;
      pt_1_q <= dt_0_q * $signed({1'b0, coeff_i.c6});
      po_1_q <= dt_0_q * $signed({1'b0, coeff_i.c4});
      ps_1_q <= dt_0_q * $signed({1'b0, coeff_i.c3});
    end
    if (rdy2) begin
      res_2_q <= res_2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = res_2_q;

endmodule

FILE: src/bsc_pres.sv
// Stages 4-6: D1*SENS as two partial products, scaling, and the pressure result.
module bsc_pres import bsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  corr_t                   in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [TempW-1:0] temp_o,
  output logic signed [PresW-1:0] pres_o
);

  logic v3_q, v4_q, v5_q;
  logic rdy3, rdy4, rdy5;

  // stage 4: partial products, SENS split at bit 18
  logic signed [41:0]      ph_3_q;
  logic [41:0]             pl_3_q;
  logic                    neg_3_q;
  logic signed [35:0]      off_3_q;
  logic signed [TempW-1:0] temp_3_q;
  // stage 5
  logic signed [38:0]      q_4_q;
  logic signed [35:0]      off_4_q;
  logic signed [TempW-1:0] temp_4_q;
  // stage 6
  logic signed [PresW-1:0] pres_5_q, pres_5_d;
  logic signed [TempW-1:0] temp_5_q;

  logic signed [59:0] x, xq;
  logic signed [39:0] diff, db, pq;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign in_ready_o = rdy3;

  // D1 is unsigned, so the sign of the product is the sign of SENS
  assign x  = $signed({ph_3_q, 18'h00000}) + $signed({18'h00000, pl_3_q})
            + (neg_3_q ? 60'sd2097151 : 60'sd0);
  assign xq = x >>> 21;

  always_comb begin
    diff = $signed({q_4_q[38], q_4_q}) - $signed({{4{off_4_q[35]}}, off_4_q});
    db   = diff + (diff[39] ? 40'sd32767 : 40'sd0);
    pq   = db >>> 15;
    if (pq > 40'sd4194303) begin
      pres_5_d = 23'sd4194303;
    end else if (pq < -40'sd4194304) begin
      pres_5_d = -23'sd4194304;
    end else begin
      pres_5_d = pq[22:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= in_valid_i;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      ph_3_q   <= $signed({1'b0, in_i.d1}) * $signed(in_i.sens[34:18]);
      pl_3_q   <= in_i.d1 * in_i.sens[17:0];
      neg_3_q  <= in_i.sens[34];
      off_3_q  <= in_i.off;
      temp_3_q <= in_i.temp;
    end
    if (rdy4) begin
      q_4_q    <= xq[38:0];
      off_4_q  <= off_3_q;
      temp_4_q <= temp_3_q;
    end
    if (rdy5) begin
      pres_5_q <= pres_5_d;
      temp_5_q <= temp_4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign temp_o      = temp_5_q;
  assign pres_o      = pres_5_q;

endmodule

FILE: src/baro_sensor_compensation.sv
// Top level of the barometric sensor first-order compensation pipeline.
//
// Usage:
//   Input channel: one request carries a raw pressure reading (D1) and a raw
//   temperature reading (D2). It is taken at a clock edge with in_valid_i
//   high and in_stall_o low.
//   Output channel: one request per input, compensated temperature in
//   hundredths of a degree and pressure in hundredths of a millibar, both
//   two's complement and saturated. Taken when out_valid_o is high and
//   out_stall_i is low.
//   Config port: cfg_we_i with cfg_index_i (0..5 = C1..C6) and cfg_wdata_i.
//   Unused indexes are dropped. Write only while the pipeline is empty.
// Throughput: one request per cycle while out_stall_i stays low, set by the
//   six-stage pipeline with its three 25x17 dT products and the D1*SENS
//   product split into two halves.
// Stall: each stage holds while the one after it is full and held, so
//   empty stages keep filling; in_stall_o rises only once all six are full.
// Reset: clears all stage valid bits and the calibration words to zero.
module baro_sensor_compensation import bsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [RawW-1:0]         raw_pressure_i,
  input  logic [RawW-1:0]         raw_temperature_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [TempW-1:0] temperature_centi_o,
  output logic signed [PresW-1:0] pressure_centi_mbar_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CoeffW-1:0]       cfg_wdata_i
);

  coeff_t coeff;
  corr_t  corr;
  logic   in_ready;
  logic   corr_valid, pres_ready;

  bsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coeff_o     (coeff)
  );

  // dT, the scaled dT terms, TEMP, OFF and SENS
  bsc_corr u_corr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coeff_i     (coeff),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .d1_i        (raw_pressure_i),
    .d2_i        (raw_temperature_i),
    .out_valid_o (corr_valid),
    .out_ready_i (pres_ready),
    .out_o       (corr)
  );

  // D1*SENS, offset removal and output register
  bsc_pres u_pres (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corr_valid),
    .in_ready_o  (pres_ready),
    .in_i        (corr),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .temp_o      (temperature_centi_o),
    .pres_o      (pressure_centi_mbar_o)
  );

  assign in_stall_o = !in_ready;

endmodule

FILE: src/bsc_checker.sv
// Port-level checks for the compensation pipeline, bound to the top level.
module bsc_checker import bsc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [TempW-1:0] temperature_centi_o,
  input logic signed [PresW-1:0] pressure_centi_mbar_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(temperature_centi_o)
                                && $stable(pressure_centi_mbar_o))
    else $error("output payload changed while stalled");

  // A free output side lets every stage advance, so input is never held
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with output side free");

  // An accepted request reaches the output when the output side is never held
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
           ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_stall_o            (in_stall_o),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .temperature_centi_o   (temperature_centi_o),
  .pressure_centi_mbar_o (pressure_centi_mbar_o)
);

FILE: sim/tb_baro_sensor_compensation.sv
`timescale 1ns / 100ps
// Testbench for baro_sensor_compensation: directed and random readings checked by an in-bench model.
module tb_baro_sensor_compensation;
  import bsc_pkg::*;

  // Indexes past the six calibration words; writes there must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  localparam int PipeDepth    = 6;              // input to output, no stall
  localparam int SettleCycles = 2 * PipeDepth;  // quiet time before a config write / the end
  localparam int QuietLimit   = 4000;           // cycles with no request moving -> hang
  localparam int ItemsPerSet  = 155;            // random readings per calibration set

  localparam longint TempMax = (longint'(1) <<< (TempW - 1)) - 1;
  localparam longint TempMin = -TempMax - 1;
  localparam longint PresMax = (longint'(1) <<< (PresW - 1)) - 1;
  localparam longint PresMin = -PresMax - 1;

  // One compensated reading as it leaves the block
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [PresW-1:0] pres;
  } reading_t;

  logic                    clk_i;
  logic                    rst_ni            = 1'b0;
  logic                    in_valid_i        = 1'b0;
  logic                    in_stall_o;
  logic [RawW-1:0]         raw_pressure_i    = '0;
  logic [RawW-1:0]         raw_temperature_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i       = 1'b0;
  logic signed [TempW-1:0] temperature_centi_o;
  logic signed [PresW-1:0] pressure_centi_mbar_o;
  logic                    cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i       = '0;
  logic [CoeffW-1:0]       cfg_wdata_i       = '0;

  // Expected readings, oldest first, and the calibration the block should hold
  reading_t pending_readings[$];
  coeff_t   cal_now = '0;

  int send_idle_pct  = 0;  // chance per cycle that the sender holds off
  int stall_pct      = 0;  // chance per cycle that the receiver stalls
  int sent_count     = 0;
  int checked_count  = 0;
  int mismatch_count = 0;
  int cal_sets       = 0;
  int quiet_cycles   = 0;

  baro_sensor_compensation u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .raw_pressure_i        (raw_pressure_i),
    .raw_temperature_i     (raw_temperature_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .temperature_centi_o   (temperature_centi_o),
    .pressure_centi_mbar_o (pressure_centi_mbar_o),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Compensation model. Everything is exact 64-bit signed math; SV signed
  // division truncates toward zero, which is what the block must do too.
  // The largest product, D1*SENS, stays under 2^59.
  // ---------------------------------------------------------------------------
  function automatic reading_t compensate(input logic [RawW-1:0] d1,
                                          input logic [RawW-1:0] d2);
    longint   c1, c2, c3, c4, c5, c6;
    longint   raw_p, raw_t, dt, offset, sens, centi, pres;
    reading_t r;
    c1 = cal_now.c1;
    c2 = cal_now.c2;
    c3 = cal_now.c3;
    c4 = cal_now.c4;
    c5 = cal_now.c5;
    c6 = cal_now.c6;
    raw_p = d1;
    raw_t = d2;
    dt     = raw_t - c5 * 256;                    // offset from reference temperature
    centi  = 2000 + (dt * c6) / 8388608;          // 20.00 C at reference
    offset = c2 * 65536 + (dt * c4) / 128;
    sens   = c1 * 32768 + (dt * c3) / 256;
    pres   = ((raw_p * sens) / 2097152 - offset) / 32768;
    // Clamp to the output field ranges (should never bite, but the block has it)
    if (centi > TempMax) centi = TempMax;
    if (centi < TempMin) centi = TempMin;
    if (pres > PresMax) pres = PresMax;
    if (pres < PresMin) pres = PresMin;
    r.temp = centi[TempW-1:0];
    r.pres = pres[PresW-1:0];
    return r;
  endfunction

  // Calibration word biased toward the ends of its range
  function automatic logic [CoeffW-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CoeffW'($urandom);
    endcase
  endfunction

  function automatic coeff_t random_cal();
    coeff_t cal;
    cal.c1 = pick_word();
    cal.c2 = pick_word();
    cal.c3 = pick_word();
    cal.c4 = pick_word();
    cal.c5 = pick_word();
    cal.c6 = pick_word();
    return cal;
  endfunction

  // Raw conversion value: mostly uniform, some extremes, some close to
  // center*256 so that dT sits near zero and changes sign
  function automatic logic [RawW-1:0] pick_raw(input logic [CoeffW-1:0] center);
    logic [RawW-1:0] r;
    r = RawW'($urandom);
    case ($urandom_range(9))
      0:       r = '0;
      1:       r = '1;
      2:       r = {center, 8'h00} + RawW'($urandom_range(511)) - RawW'(256);
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Valid stays high from one request to the next unless the
  // sender decides to idle; junk goes on the payload while valid is low.
  // ---------------------------------------------------------------------------
  task automatic send_reading(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i        <= 1'b0;
      raw_pressure_i    <= RawW'($urandom);
      raw_temperature_i <= RawW'($urandom);
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    do @(posedge clk_i); while (in_stall_o);
    pending_readings.push_back(compensate(d1, d2));
    sent_count++;
  endtask

  // Wait for every expected reading, then let the pipe settle
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable after a burst
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoeffW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_C1:  cal_now.c1 = val;
      REG_C2:  cal_now.c2 = val;
      REG_C3:  cal_now.c3 = val;
      REG_C4:  cal_now.c4 = val;
      REG_C5:  cal_now.c5 = val;
      REG_C6:  cal_now.c6 = val;
      default: ;  // spare index, ignored by the block
    endcase
  endtask

  // Load a full calibration set, with a stray write to a spare index around it
  task automatic program_cal(input coeff_t cal);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CoeffW'($urandom));
    write_reg(REG_C1, cal.c1);
    write_reg(REG_C2, cal.c2);
    write_reg(REG_C3, cal.c3);
    write_reg(REG_C4, cal.c4);
    write_reg(REG_C5, cal.c5);
    write_reg(REG_C6, cal.c6);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CoeffW'($urandom));
    cfg_we_i <= 1'b0;
    cal_sets++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Calibration still at its reset value of all zeros
  task automatic test_zero_cal();
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading('1, '0);
    send_reading('0, '1);
    drain_pipe();
  endtask

  // Range ends of the calibration words and readings, plus a typical part
  task automatic test_directed_cal();
    coeff_t cal;
    cal = '1;                                   // every word at full scale
    program_cal(cal);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading('1, '0);                       // most negative dT
    send_reading('0, '1);
    send_reading('1, {cal.c5, 8'h00});          // dT exactly zero
    drain_pipe();

    cal = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
            c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
    program_cal(cal);
    send_reading(24'd9085466, 24'd8569150);     // typical room conditions
    send_reading(24'd9085466, {cal.c5, 8'h00} - 24'd1);
    send_reading(24'd4000000, {cal.c5, 8'h00} + 24'd1);
    drain_pipe();

    // Largest sensitivity against a low temperature reading
    program_cal('{c1: '1, c2: '0, c3: '1, c4: '0, c5: '1, c6: '1});
    send_reading('1, '0);
    send_reading('1, '1);
    drain_pipe();

    // Largest offset with no temperature reference
    program_cal('{c1: '0, c2: '1, c3: '1, c4: '1, c5: '0, c6: '0});
    send_reading('1, '1);
    send_reading('0, '1);
    drain_pipe();

    // Alternating bit patterns
    program_cal('{c1: 16'hAAAA, c2: 16'h5555, c3: 16'hAAAA,
                  c4: 16'h5555, c5: 16'hAAAA, c6: 16'h5555});
    send_reading(24'hAAAAAA, 24'h555555);
    send_reading(24'h555555, 24'hAAAAAA);
    drain_pipe();
  endtask

  // Random readings over two random calibration sets at one idle mix
  task automatic test_random_traffic(input int idle_pct, input int stall_chance);
    send_idle_pct = idle_pct;
    stall_pct     = stall_chance;
    repeat (2) begin
      program_cal(random_cal());
      repeat (ItemsPerSet)
        send_reading(pick_raw(CoeffW'($urandom)), pick_raw(cal_now.c5));
      drain_pipe();
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: one fresh draw per cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker and hang watchdog. Both sample pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if ((in_valid_i && !in_stall_o) || cfg_we_i) quiet_cycles = 0;
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        if (pending_readings.size() == 0) begin
          mismatch_count++;
          $error("unexpected result: temperature_centi %0d, pressure_centi_mbar %0d",
                 temperature_centi_o, pressure_centi_mbar_o);
        end else begin
          want = pending_readings.pop_front();
          checked_count++;
          if (temperature_centi_o !== want.temp) begin
            mismatch_count++;
            $error("temperature_centi: expected %0d, got %0d",
                   $signed(want.temp), temperature_centi_o);
          end
          if (pressure_centi_mbar_o !== want.pres) begin
            mismatch_count++;
            $error("pressure_centi_mbar: expected %0d, got %0d",
                   $signed(want.pres), pressure_centi_mbar_o);
          end
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                 QuietLimit, pending_readings.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_cal();
    test_directed_cal();
    test_random_traffic(0, 0);    // full rate both ways
    test_random_traffic(68, 0);   // sparse sender
    test_random_traffic(0, 68);   // heavy back-pressure
    test_random_traffic(13, 13);  // light gaps on both sides

    $display("Ran %0d readings across %0d calibration loads; %0d results checked, %0d mismatches",
             sent_count, cal_sets, checked_count, mismatch_count);
    $display("Traffic mixes: full rate, sender gaps, receiver stalls, and both");
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
